>>> design/rtphe_pkg.sv
// rtphe_pkg: shared types and constants of the RTP header engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package rtphe_pkg;

  // configuration register indexes
  typedef logic [3:0] cfg_idx_t;
  localparam cfg_idx_t REG_MODE_REALTIME   = 4'd0;
  localparam cfg_idx_t REG_MAX_PAYLOAD     = 4'd1;
  localparam cfg_idx_t REG_AUDIO_SSRC      = 4'd2;
  localparam cfg_idx_t REG_VIDEO_SSRC      = 4'd3;
  localparam cfg_idx_t REG_AUDIO_SEQ_START = 4'd4;
  localparam cfg_idx_t REG_VIDEO_SEQ_START = 4'd5;
  localparam cfg_idx_t REG_AUDIO_TS_START  = 4'd6;
  localparam cfg_idx_t REG_VIDEO_TS_START  = 4'd7;

  // register reset values
  localparam logic        MODE_REALTIME_RST = 1'b1;
  localparam logic [10:0] MAX_PAYLOAD_RST   = 11'd1400;
  localparam logic [31:0] AUDIO_SSRC_RST    = 32'd1;
  localparam logic [31:0] VIDEO_SSRC_RST    = 32'd2;
  localparam logic [15:0] SEQ_START_RST     = 16'd1;
  localparam logic [31:0] TS_START_RST      = 32'd1;

  localparam logic [10:0] PAYLOAD_MIN = 11'd1024;
  localparam logic [10:0] PAYLOAD_MAX = 11'd1588;
  localparam logic [10:0] HDR_BYTES   = 11'd12;

  localparam logic [6:0] AUDIO_PAYLOAD_TYPE = 7'd97;
  localparam logic [6:0] VIDEO_PAYLOAD_TYPE = 7'd96;

  // media clock per ms: 16 kHz audio, 90 kHz video
  localparam logic [6:0] AUDIO_CLK_SCALE = 7'd16;
  localparam logic [6:0] VIDEO_CLK_SCALE = 7'd90;

  // x / 1000 == (x * ceil(2^41 / 1000)) >> 41, exact for all 32-bit x
  localparam logic [31:0] RECIP_1000  = 32'd2199023256;
  localparam int          RECIP_SHIFT = 41;
  localparam int          QUOT_W      = 64 - RECIP_SHIFT;

  typedef struct packed {
    logic        mode_realtime;
    logic [10:0] max_payload;
    logic [31:0] audio_ssrc;
    logic [31:0] video_ssrc;
    logic [15:0] audio_seq_start;
    logic [15:0] video_seq_start;
    logic [31:0] audio_ts_start;
    logic [31:0] video_ts_start;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic restart;
    logic load;
    logic scale;
    logic divide;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic restart_req;
    logic empty_frame;
    logic last_packet;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> design/rtphe_regs.sv
// rtphe_regs: configuration register file of the RTP header engine.
// Depends on rtphe_pkg.
`default_nettype none

module rtphe_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  rtphe_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]         cfg_data,
  output rtphe_pkg::cfg_t     cfg
);
  import rtphe_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_realtime   <= MODE_REALTIME_RST;
      cfg.max_payload     <= MAX_PAYLOAD_RST;
      cfg.audio_ssrc      <= AUDIO_SSRC_RST;
      cfg.video_ssrc      <= VIDEO_SSRC_RST;
      cfg.audio_seq_start <= SEQ_START_RST;
      cfg.video_seq_start <= SEQ_START_RST;
      cfg.audio_ts_start  <= TS_START_RST;
      cfg.video_ts_start  <= TS_START_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE_REALTIME:   cfg.mode_realtime   <= cfg_data[0];
        REG_MAX_PAYLOAD:     cfg.max_payload     <= cfg_data[10:0];
        REG_AUDIO_SSRC:      cfg.audio_ssrc      <= cfg_data;
        REG_VIDEO_SSRC:      cfg.video_ssrc      <= cfg_data;
        REG_AUDIO_SEQ_START: cfg.audio_seq_start <= cfg_data[15:0];
        REG_VIDEO_SEQ_START: cfg.video_seq_start <= cfg_data[15:0];
        REG_AUDIO_TS_START:  cfg.audio_ts_start  <= cfg_data;
        REG_VIDEO_TS_START:  cfg.video_ts_start  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/rtphe_ctrl.sv
// rtphe_ctrl: sequencing state machine of the RTP header engine.
// Depends on rtphe_pkg; drives rtphe_dp through dp_cmd_t.
`default_nettype none

module rtphe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  output logic                frame_stall,
  input  rtphe_pkg::dp_stat_t stat,
  output rtphe_pkg::dp_cmd_t  ctl
);
  import rtphe_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctl         = '0;
    frame_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (frame_valid) begin
          if (stat.restart_req) begin
            ctl.restart = 1'b1;
          end else if (!stat.empty_frame) begin
            ctl.load   = 1'b1;
            state_next = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        ctl.scale  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        ctl.divide = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          ctl.emit = 1'b1;
          if (stat.last_packet) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> design/rtphe_dp.sv
// rtphe_dp: session state, timestamp arithmetic and packet output register.
// Depends on rtphe_pkg; sequenced by rtphe_ctrl.
`default_nettype none

module rtphe_dp (
  input  logic                clk,
  input  logic                rst,
  input  rtphe_pkg::cfg_t     cfg,
  input  rtphe_pkg::dp_cmd_t  ctl,
  output rtphe_pkg::dp_stat_t stat,
  input  logic                cmd,
  input  logic                stream_sel,
  input  logic [31:0]         frame_time,
  input  logic [15:0]         frame_size,
  output logic                pkt_valid,
  input  logic                pkt_stall,
  output logic                stream_id,
  output logic [15:0]         seq_number,
  output logic [31:0]         rtp_timestamp,
  output logic [31:0]         ssrc_out,
  output logic [6:0]          payload_kind,
  output logic                marker,
  output logic [15:0]         payload_offset,
  output logic [10:0]         payload_length,
  output logic [10:0]         packet_length,
  output logic [31:0]         packet_total,
  output logic [31:0]         octet_total
);
  import rtphe_pkg::*;

  // per-session state, index 0 audio, 1 video
  logic [15:0] seq     [2];
  logic [31:0] ts_base [2];
  logic [31:0] pkt_cnt [2];
  logic [31:0] oct_cnt [2];

  // current frame
  logic        sel;
  logic [31:0] ftime;
  logic [15:0] remain;
  logic [15:0] offset;
  logic [31:0] scaled;
  logic [63:0] prod;

  logic [10:0]       limit;
  logic [10:0]       len;
  logic [15:0]       len16;
  logic              last;
  logic [6:0]        factor;
  logic [38:0]       scale_full;
  logic [63:0]       prod_full;
  logic [QUOT_W-1:0] quot;
  logic [31:0]       ts_val;
  logic [31:0]       pkt_next;
  logic [31:0]       oct_next;

  always_comb begin
    if (cfg.max_payload < PAYLOAD_MIN) begin
      limit = PAYLOAD_MIN;
    end else if (cfg.max_payload > PAYLOAD_MAX) begin
      limit = PAYLOAD_MAX;
    end else begin
      limit = cfg.max_payload;
    end
  end

  assign last  = (remain <= {5'b0, limit});
  assign len   = last ? remain[10:0] : limit;
  assign len16 = {5'b0, len};

  assign factor     = sel ? VIDEO_CLK_SCALE : AUDIO_CLK_SCALE;
  assign scale_full = {7'b0, ftime} * {32'b0, factor};
  assign prod_full  = {32'b0, scaled} * {32'b0, RECIP_1000};
  assign quot       = prod[63:RECIP_SHIFT];

  assign ts_val   = cfg.mode_realtime ? ts_base[sel] + {{(32-QUOT_W){1'b0}}, quot}
                                      : ts_base[sel];
  assign pkt_next = pkt_cnt[sel] + 32'd1;
  assign oct_next = oct_cnt[sel] + {21'b0, len};

  assign stat.restart_req = !cmd;
  assign stat.empty_frame = (frame_size == 16'd0);
  assign stat.last_packet = last;
  assign stat.out_free    = !pkt_valid || !pkt_stall;

  // control and session state
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        seq[i]     <= SEQ_START_RST;
        ts_base[i] <= TS_START_RST;
        pkt_cnt[i] <= '0;
        oct_cnt[i] <= '0;
      end
    end else begin
      if (ctl.emit) begin
        pkt_valid <= 1'b1;
      end else if (!pkt_stall) begin
        pkt_valid <= 1'b0;
      end
      if (ctl.restart) begin
        seq[0]     <= cfg.audio_seq_start;
        seq[1]     <= cfg.video_seq_start;
        ts_base[0] <= cfg.audio_ts_start;
        ts_base[1] <= cfg.video_ts_start;
        pkt_cnt[0] <= '0;
        pkt_cnt[1] <= '0;
        oct_cnt[0] <= '0;
        oct_cnt[1] <= '0;
      end
      if (ctl.emit) begin
        seq[sel]     <= seq[sel] + 16'd1;
        pkt_cnt[sel] <= pkt_next;
        oct_cnt[sel] <= oct_next;
        if (last && !cfg.mode_realtime) begin
          ts_base[sel] <= ts_base[sel] + scaled;
        end
      end
    end
  end

  // frame working registers and output payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sel    <= stream_sel;
      ftime  <= frame_time;
      remain <= frame_size;
      offset <= '0;
    end
    if (ctl.scale) begin
      scaled <= scale_full[31:0];
    end
    if (ctl.divide) begin
      prod <= prod_full;
    end
    if (ctl.emit) begin
      remain         <= remain - len16;
      offset         <= offset + len16;
      stream_id      <= sel;
      seq_number     <= seq[sel];
      rtp_timestamp  <= ts_val;
      ssrc_out       <= sel ? cfg.video_ssrc : cfg.audio_ssrc;
      payload_kind   <= sel ? VIDEO_PAYLOAD_TYPE : AUDIO_PAYLOAD_TYPE;
      marker         <= last;
      payload_offset <= offset;
      payload_length <= len;
      packet_length  <= len + HDR_BYTES;
      packet_total   <= pkt_next;
      octet_total    <= oct_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!pkt_valid || !pkt_stall))
    else $error("packet issued over an unaccepted packet");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && last) |=> (remain == 16'd0))
    else $error("bytes left after marker packet");

  a_marker_tracks_last: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> (marker == $past(last)))
    else $error("marker does not match end of frame");

  a_nonempty_payload: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (len != 11'd0))
    else $error("zero-length packet issued");
`endif

endmodule

`default_nettype wire

>>> design/rtp_packetizer_header_engine_core.sv
// Top level of the RTP packetizer header engine: splits frame descriptors into
// RTP header records. Depends on rtphe_pkg, rtphe_regs, rtphe_ctrl, rtphe_dp.
// A loaded frame steps through a scale multiply and a reciprocal multiply, then
// the output register issues one header per free output cycle; frame_stall is
// held from the scale step until the marker packet of the frame is issued.
// Restart and empty-frame transactions are taken in idle without leaving it.
// Reset (rst, synchronous) loads register defaults and session start values.
`default_nettype none

module rtp_packetizer_header_engine_core (
  input  logic                clk,
  input  logic                rst,

  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  rtphe_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]         cfg_data,

  // frame descriptor channel
  input  logic                frame_valid,
  output logic                frame_stall,
  input  logic                cmd,
  input  logic                stream_sel,
  input  logic [31:0]         frame_time,
  input  logic [15:0]         frame_size,

  // packet header channel
  output logic                pkt_valid,
  input  logic                pkt_stall,
  output logic                stream_id,
  output logic [15:0]         seq_number,
  output logic [31:0]         rtp_timestamp,
  output logic [31:0]         ssrc_out,
  output logic [6:0]          payload_kind,
  output logic                marker,
  output logic [15:0]         payload_offset,
  output logic [10:0]         payload_length,
  output logic [10:0]         packet_length,
  output logic [31:0]         packet_total,
  output logic [31:0]         octet_total
);
  import rtphe_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  ctl;
  dp_stat_t stat;

  // register file; writes are only expected between frames
  rtphe_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: idle -> scale -> divide -> emit (one packet per free cycle)
  rtphe_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .stat        (stat),
    .ctl         (ctl)
  );

  // session counters, timestamp math and the output register
  rtphe_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .ctl            (ctl),
    .stat           (stat),
    .cmd            (cmd),
    .stream_sel     (stream_sel),
    .frame_time     (frame_time),
    .frame_size     (frame_size),
    .pkt_valid      (pkt_valid),
    .pkt_stall      (pkt_stall),
    .stream_id      (stream_id),
    .seq_number     (seq_number),
    .rtp_timestamp  (rtp_timestamp),
    .ssrc_out       (ssrc_out),
    .payload_kind   (payload_kind),
    .marker         (marker),
    .payload_offset (payload_offset),
    .payload_length (payload_length),
    .packet_length  (packet_length),
    .packet_total   (packet_total),
    .octet_total    (octet_total)
  );

endmodule

`default_nettype wire
